[hw/rtl/pfs_pkg.sv]
// Shared types and constants for the protobuf field serializer.
`timescale 1ns / 1ps

package pfs_pkg;

    // Item kinds as presented at the input
    localparam logic [1:0] KIND_VARINT  = 2'd0;
    localparam logic [1:0] KIND_FIXED64 = 2'd1;
    localparam logic [1:0] KIND_LENGTH  = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    // Wire types placed in the low bits of the tag
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;

    localparam int FN_W        = 29;
    localparam int TAG_W       = FN_W + 3;
    localparam int BODY_W      = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_VARINT,
        MODE_FIXED,
        MODE_PASS
    } pfs_mode_t;

    // One classified request, as passed from front to back
    typedef struct packed {
        pfs_mode_t           mode;
        logic [TAG_W-1:0]    tag;
        logic [BODY_W-1:0]   body;
        logic                row_end;
    } pfs_entry_t;

endpackage

[hw/rtl/pfs_front.sv]
// Front end: accepts requests and classifies them into queue entries.
`timescale 1ns / 1ps

module pfs_front
    import pfs_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [FN_W-1:0]   field_number,
    input  logic [63:0]       value,
    input  logic [31:0]       length,
    input  logic [7:0]        payload_byte,
    input  logic              row_end,
    input  logic              q_full,
    output logic              q_push,
    output pfs_entry_t        q_entry
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.row_end = row_end;
        q_entry.tag     = {field_number, WIRE_VARINT};
        q_entry.body    = value;
        q_entry.mode    = MODE_VARINT;
        unique case (kind)
            KIND_VARINT:
            begin
                q_entry.tag  = {field_number, WIRE_VARINT};
                q_entry.body = value;
                q_entry.mode = MODE_VARINT;
            end
            KIND_FIXED64:
            begin
                q_entry.tag  = {field_number, WIRE_FIXED64};
                q_entry.body = value;
                q_entry.mode = MODE_FIXED;
            end
            KIND_LENGTH:
            begin
                q_entry.tag  = {field_number, WIRE_LENGTH};
                q_entry.body = {32'd0, length};
                q_entry.mode = MODE_VARINT;
            end
            KIND_PAYLOAD:
            begin
                // no tag; the back end skips straight to the body
                q_entry.body = {56'd0, payload_byte};
                q_entry.mode = MODE_PASS;
            end
            default:
            begin
                q_entry.mode = MODE_PASS;
            end
        endcase
    end

endmodule

[hw/rtl/pfs_queue.sv]
// Short entry queue between front and back ends.
`timescale 1ns / 1ps

module pfs_queue
    import pfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  pfs_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output pfs_entry_t  pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pfs_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/pfs_back.sv]
// Back end: byte sequencer that emits tag and body bytes into the output register.
`timescale 1ns / 1ps

module pfs_back
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  pfs_entry_t  q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        item_last,
    output logic        row_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAG,
        ST_BODY
    } state_t;

    state_t             state_reg;
    pfs_mode_t          mode_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [BODY_W-1:0]  body_reg;
    logic               row_end_reg;
    logic [2:0]         cnt_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               item_last_reg;
    logic               row_last_reg;

    logic               adv;
    logic               emit;
    logic               tag_more;
    logic               body_more;
    logic [7:0]         byte_next;
    logic               last_next;

    // output register is free, or its byte goes out this cycle
    assign adv       = !out_valid_reg || !out_stall;
    assign emit      = (state_reg != ST_IDLE) && adv;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign tag_more  = |tag_reg[TAG_W-1:7];
    assign body_more = |body_reg[BODY_W-1:7];

    always_comb
    begin
        byte_next = 8'd0;
        last_next = 1'b0;
        unique case (state_reg)
            ST_TAG:
            begin
                byte_next = {tag_more, tag_reg[6:0]};
                last_next = 1'b0;
            end
            ST_BODY:
            begin
                case (mode_reg)
                    MODE_VARINT:
                    begin
                        byte_next = {body_more, body_reg[6:0]};
                        last_next = !body_more;
                    end
                    MODE_FIXED:
                    begin
                        byte_next = body_reg[7:0];
                        last_next = (cnt_reg == 3'd7);
                    end
                    default:
                    begin
                        byte_next = body_reg[7:0];
                        last_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                byte_next = 8'd0;
                last_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_PASS;
            tag_reg       <= '0;
            body_reg      <= '0;
            row_end_reg   <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            item_last_reg <= 1'b0;
            row_last_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= emit;
                if (emit)
                begin
                    out_byte_reg  <= byte_next;
                    item_last_reg <= last_next;
                    row_last_reg  <= last_next && row_end_reg;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        mode_reg    <= q_entry.mode;
                        tag_reg     <= q_entry.tag;
                        body_reg    <= q_entry.body;
                        row_end_reg <= q_entry.row_end;
                        cnt_reg     <= 3'd0;
                        state_reg   <= (q_entry.mode == MODE_PASS) ? ST_BODY : ST_TAG;
                    end
                end
                ST_TAG:
                begin
                    if (adv)
                    begin
                        if (tag_more)
                        begin
                            tag_reg <= tag_reg >> 7;
                        end
                        else
                        begin
                            state_reg <= ST_BODY;
                        end
                    end
                end
                ST_BODY:
                begin
                    if (adv)
                    begin
                        if (last_next)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            body_reg <= (mode_reg == MODE_FIXED) ? (body_reg >> 8)
                                                                 : (body_reg >> 7);
                            cnt_reg  <= cnt_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign item_last = item_last_reg;
    assign row_last  = row_last_reg;

endmodule

[hw/rtl/protobuf_field_serializer.sv]
// Top level of the protobuf wire-format field serializer.
`timescale 1ns / 1ps

// Each request is one field (varint, fixed64 or length-delimited header) or one
// string payload byte, and comes out as its wire bytes, one byte per cycle on the
// out channel while out_stall is low, with item_last on the final byte and
// row_last as well when row_end was set. The front end classifies a request and
// forms its tag in the cycle it is accepted, then parks it in a QUEUE_DEPTH-entry
// queue, so requests keep being taken while earlier ones are serialized. The back
// end loads an entry in its idle state and then emits its bytes, and takes no new
// entry until it is through with the current one. A request's byte count is 2 to
// 15 for varint fields, 9 to 13 for fixed64, 2 to 10 for length headers and 1 for
// payload bytes. There is no configuration and no state kept between requests.
module protobuf_field_serializer
    import pfs_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [FN_W-1:0]   field_number,
    input  logic [63:0]       value,
    input  logic [31:0]       length,
    input  logic [7:0]        payload_byte,
    input  logic              row_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              item_last,
    output logic              row_last
);

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    pfs_entry_t  push_entry;
    pfs_entry_t  pop_entry;

    pfs_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .field_number (field_number),
        .value        (value),
        .length       (length),
        .payload_byte (payload_byte),
        .row_end      (row_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_entry      (push_entry)
    );

    pfs_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    pfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_entry   (pop_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .item_last (item_last),
        .row_last  (row_last)
    );

endmodule

[hw/rtl/pfs_checker.sv]
// Port-level checks for the serializer, bound to the top level.
`timescale 1ns / 1ps

module pfs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        item_last,
    input  logic        row_last
);

    // a stalled output byte holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(item_last) && $stable(row_last)
    ) else $error("stalled output byte changed");

    // row end only ever falls on the last byte of a request
    a_row_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && row_last |-> item_last
    ) else $error("row_last without item_last");

    // bytes of one request come out without gaps
    a_no_gap: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !item_last |=> out_valid
    ) else $error("gap inside a request's bytes");

endmodule

bind protobuf_field_serializer pfs_checker u_pfs_checker (.*);
